// ----- hdl/ilsc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ilsc_pkg
// Shared types and constants of the two-axis iterative learning servo control
// ----------------------------------------------------------------------------
package ilsc_pkg;

   // trajectory store
   localparam int MAX_TRAJECTORY = 32;
   localparam int IDX_W          = $clog2(MAX_TRAJECTORY);
   localparam int TRAJ_W         = 6;
   localparam int CNT_W          = (IDX_W + 1 > TRAJ_W) ? IDX_W + 1 : TRAJ_W;

   // field widths
   localparam int ANGLE_IN_W  = 11;
   localparam int DRIVE_W     = 10;
   localparam int ANGLE_OUT_W = 11;
   localparam int PASS_W      = 3;
   localparam int GAIN_W      = 8;
   localparam int MGAIN_W     = 7;
   localparam int OFFSET_W    = 8;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_LEARNING_GAIN      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PASS_LIMIT         = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRAJECTORY_LENGTH  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODEL_GAIN_PERCENT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODEL_OFFSET       = 3'd4;

   // register reset values
   localparam logic [GAIN_W-1:0]   RST_LEARNING_GAIN = 8'd47;
   localparam logic [PASS_W-1:0]   RST_PASS_LIMIT    = 3'd5;
   localparam logic [TRAJ_W-1:0]   RST_TRAJ_LENGTH   = 6'd20;
   localparam logic [MGAIN_W-1:0]  RST_MODEL_GAIN    = 7'd60;
   localparam logic [OFFSET_W-1:0] RST_MODEL_OFFSET  = 8'd20;

   // pwm and angle limits
   localparam logic [DRIVE_W-1:0]     PWM_LOW    = 10'd500;
   localparam logic [DRIVE_W-1:0]     PWM_HIGH   = 10'd1000;
   localparam logic [ANGLE_IN_W-1:0]  ANGLE_FULL = 11'd1800;
   localparam logic [ANGLE_OUT_W-1:0] ANGLE_MAX  = 11'd2047;

   // shared multiplier
   localparam int MUL_A_W = 19;
   localparam int MUL_B_W = 21;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // reciprocal constants, each exact over its operand range
   // angle * 5/18 as (x * K) >> 20
   localparam logic [MUL_B_W-1:0] K_DRIVE  = 21'd291275;
   // (drive - 500) * 18/5 as (x * K) >> 16
   localparam logic [MUL_B_W-1:0] K_IDEAL  = 21'd235930;
   // x / 100 for x below 2^18 as (x * K) >> 25
   localparam logic [MUL_B_W-1:0] K_DIV100 = 21'd335545;
   // x / 100 for x below 2^19 as (x * K) >> 27
   localparam logic [MUL_B_W-1:0] K_DIVG   = 21'd1342178;

   localparam int SH_DRIVE  = 20;
   localparam int SH_IDEAL  = 16;
   localparam int SH_DIV100 = 25;
   localparam int SH_DIVG   = 27;

   // sequencer states
   typedef enum logic [10:0] {
      ST_IDLE   = 11'b000_0000_0001,
      ST_DRV    = 11'b000_0000_0010,
      ST_DRVSEL = 11'b000_0000_0100,
      ST_IDEAL  = 11'b000_0000_1000,
      ST_SCALE  = 11'b000_0001_0000,
      ST_DIV    = 11'b000_0010_0000,
      ST_ANGLE  = 11'b000_0100_0000,
      ST_GAIN   = 11'b000_1000_0000,
      ST_DIVG   = 11'b001_0000_0000,
      ST_UPD    = 11'b010_0000_0000,
      ST_OUT    = 11'b100_0000_0000
   } state_type;

endpackage : ilsc_pkg
`default_nettype wire

// ----- hdl/iterative_learning_servo_control.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iterative_learning_servo_control
// Two-axis p-type iterative learning servo controller with a servo model
// ----------------------------------------------------------------------------
// An item runs from acceptance through the states ST_DRV to ST_UPD for each
// axis and then ST_OUT, which loads the result; once all passes are complete
// it goes straight to ST_OUT. The next item is taken in the cycle after the
// result loads at the earliest, so items never overlap. The work shares one
// 19 x 21 bit multiplier with a registered product: each axis runs six
// multiplications (pass-0 drive, ideal angle, model gain, divide by 100,
// learning gain, divide by 100), horizontal first, then vertical.
// req_stall is high while an item is in work. The result sits in an output
// register; the block waits only if a previous result has not been taken.
// Configuration writes are always taken (csr_ready is tied high) and should
// only be made while the block is idle.
module iterative_learning_servo_control
   import ilsc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // input items
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [ANGLE_IN_W-1:0]  req_desired_horizontal,
   input  wire logic [ANGLE_IN_W-1:0]  req_desired_vertical,
   // result items
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [DRIVE_W-1:0]          rsp_drive_horizontal,
   output logic [DRIVE_W-1:0]          rsp_drive_vertical,
   output logic [ANGLE_OUT_W-1:0]      rsp_angle_horizontal,
   output logic [ANGLE_OUT_W-1:0]      rsp_angle_vertical,
   output logic                        rsp_pass_end,
   output logic [PASS_W-1:0]           rsp_pass_number,
   output logic                        rsp_finished,
   // configuration
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   // configuration registers
   logic [GAIN_W-1:0]   learning_gain_ff;
   logic [PASS_W-1:0]   pass_limit_ff;
   logic [TRAJ_W-1:0]   traj_length_ff;
   logic [MGAIN_W-1:0]  model_gain_ff;
   logic [OFFSET_W-1:0] model_offset_ff;

   // control state
   state_type         state_ff, state_in;
   logic              axis_ff, axis_in;
   logic              item_done_ff, item_done_in;
   logic [IDX_W-1:0]  sample_index_ff, sample_index_in;
   logic [PASS_W-1:0] pass_count_ff, pass_count_in;
   logic              done_flag_ff, done_flag_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic [ANGLE_IN_W-1:0]  desired_h_ff, desired_v_ff;
   logic [DRIVE_W-1:0]     drv_ff;
   logic [ANGLE_OUT_W-1:0] angle_ff;
   logic                   err_neg_ff;
   logic [DRIVE_W-1:0]     hold_drv_h_ff;
   logic [ANGLE_OUT_W-1:0] hold_angle_h_ff;
   logic [PROD_W-1:0]      prod_ff;

   // drive tables
   logic [DRIVE_W-1:0] table_h_mem [MAX_TRAJECTORY];
   logic [DRIVE_W-1:0] table_v_mem [MAX_TRAJECTORY];
   logic [DRIVE_W-1:0] rd_h_ff, rd_v_ff;

   // output payload
   logic [DRIVE_W-1:0]     out_drv_h_ff, out_drv_v_ff;
   logic [ANGLE_OUT_W-1:0] out_angle_h_ff, out_angle_v_ff;
   logic                   out_pass_end_ff;
   logic [PASS_W-1:0]      out_pass_number_ff;
   logic                   out_finished_ff;

   // combinational
   logic                   req_accept;
   logic                   out_free;
   logic                   out_load;
   logic [ANGLE_IN_W-1:0]  desired_cur;
   logic [ANGLE_IN_W-1:0]  desired_clip;
   logic [DRIVE_W-1:0]     drv_pass0;
   logic [DRIVE_W-1:0]     drv_clamped;
   logic [DRIVE_W-1:0]     drv_span;
   logic [12:0]            angle_sum;
   logic signed [11:0]     err;
   logic signed [11:0]     err_negated;
   logic [10:0]            err_mag;
   logic [12:0]            delta;
   logic signed [14:0]     next_drv;
   logic [DRIVE_W-1:0]     new_drv;
   logic                   wr_h, wr_v;
   logic [MUL_A_W-1:0]     mul_a;
   logic [MUL_B_W-1:0]     mul_b;
   logic [CNT_W-1:0]       len_eff;
   logic [CNT_W-1:0]       idx_next;
   logic [PASS_W-1:0]      limit_eff;
   logic [PASS_W-1:0]      pass_next;
   logic                   last_sample;
   logic                   done_next;

   assign csr_ready  = 1'b1;
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign out_load   = (state_ff == ST_OUT) && out_free;

   // configuration register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         learning_gain_ff <= RST_LEARNING_GAIN;
         pass_limit_ff    <= RST_PASS_LIMIT;
         traj_length_ff   <= RST_TRAJ_LENGTH;
         model_gain_ff    <= RST_MODEL_GAIN;
         model_offset_ff  <= RST_MODEL_OFFSET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LEARNING_GAIN:      learning_gain_ff <= csr_wdata[GAIN_W-1:0];
            CSR_PASS_LIMIT:         pass_limit_ff    <= csr_wdata[PASS_W-1:0];
            CSR_TRAJECTORY_LENGTH:  traj_length_ff   <= csr_wdata[TRAJ_W-1:0];
            CSR_MODEL_GAIN_PERCENT: model_gain_ff    <= csr_wdata[MGAIN_W-1:0];
            CSR_MODEL_OFFSET:       model_offset_ff  <= csr_wdata[OFFSET_W-1:0];
            default: ;
         endcase
      end
   end

   // per-axis arithmetic around the shared multiplier
   always_comb begin
      desired_cur  = axis_ff ? desired_v_ff : desired_h_ff;
      desired_clip = (desired_cur > ANGLE_FULL) ? ANGLE_FULL : desired_cur;
      drv_pass0    = PWM_LOW + DRIVE_W'(prod_ff[SH_DRIVE +: 9]);

      // servo model input clamp
      if (drv_ff < PWM_LOW) begin
         drv_clamped = PWM_LOW;
      end else if (drv_ff > PWM_HIGH) begin
         drv_clamped = PWM_HIGH;
      end else begin
         drv_clamped = drv_ff;
      end
      drv_span = drv_clamped - PWM_LOW;

      // modelled angle with offset, saturated
      angle_sum = 13'(prod_ff[SH_DIV100 +: 12]) + 13'(model_offset_ff);

      // tracking error as sign and magnitude
      err         = $signed({1'b0, desired_cur}) - $signed({1'b0, angle_ff});
      err_negated = -err;
      err_mag     = err[11] ? err_negated[10:0] : err[10:0];

      // learning update, clamped to the pwm range
      delta    = prod_ff[SH_DIVG +: 13];
      next_drv = err_neg_ff ? ($signed({5'b0, drv_ff}) - $signed({2'b0, delta}))
                            : ($signed({5'b0, drv_ff}) + $signed({2'b0, delta}));
      if (next_drv < $signed({5'b0, PWM_LOW})) begin
         new_drv = PWM_LOW;
      end else if (next_drv > $signed({5'b0, PWM_HIGH})) begin
         new_drv = PWM_HIGH;
      end else begin
         new_drv = next_drv[DRIVE_W-1:0];
      end

      wr_h = (state_ff == ST_UPD) && !axis_ff;
      wr_v = (state_ff == ST_UPD) && axis_ff;
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_DRV: begin
            mul_a = MUL_A_W'(desired_clip);
            mul_b = K_DRIVE;
         end
         ST_IDEAL: begin
            mul_a = MUL_A_W'(drv_span);
            mul_b = K_IDEAL;
         end
         ST_SCALE: begin
            mul_a = MUL_A_W'(prod_ff[SH_IDEAL +: 11]);
            mul_b = MUL_B_W'(model_gain_ff);
         end
         ST_DIV: begin
            mul_a = MUL_A_W'(prod_ff[17:0]);
            mul_b = K_DIV100;
         end
         ST_GAIN: begin
            mul_a = MUL_A_W'(err_mag);
            mul_b = MUL_B_W'(learning_gain_ff);
         end
         ST_DIVG: begin
            mul_a = prod_ff[MUL_A_W-1:0];
            mul_b = K_DIVG;
         end
         default: ;
      endcase
   end

   // end-of-item bookkeeping
   always_comb begin
      if (traj_length_ff == '0) begin
         len_eff = CNT_W'(1);
      end else if (CNT_W'(traj_length_ff) > CNT_W'(MAX_TRAJECTORY)) begin
         len_eff = CNT_W'(MAX_TRAJECTORY);
      end else begin
         len_eff = CNT_W'(traj_length_ff);
      end
      limit_eff   = (pass_limit_ff == '0) ? PASS_W'(1) : pass_limit_ff;
      idx_next    = CNT_W'(sample_index_ff) + CNT_W'(1);
      last_sample = (idx_next >= len_eff);
      pass_next   = pass_count_ff + PASS_W'(1);
      done_next   = last_sample && (pass_next >= limit_eff);
   end

   // sequencer
   always_comb begin
      state_in        = state_ff;
      axis_in         = axis_ff;
      item_done_in    = item_done_ff;
      sample_index_in = sample_index_ff;
      pass_count_in   = pass_count_ff;
      done_flag_in    = done_flag_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               axis_in      = 1'b0;
               item_done_in = done_flag_ff;
               state_in     = done_flag_ff ? ST_OUT : ST_DRV;
            end
         end
         ST_DRV:    state_in = ST_DRVSEL;
         ST_DRVSEL: state_in = ST_IDEAL;
         ST_IDEAL:  state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_DIV;
         ST_DIV:    state_in = ST_ANGLE;
         ST_ANGLE:  state_in = ST_GAIN;
         ST_GAIN:   state_in = ST_DIVG;
         ST_DIVG:   state_in = ST_UPD;
         ST_UPD: begin
            if (!axis_ff) begin
               axis_in  = 1'b1;
               state_in = ST_DRV;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (!item_done_ff) begin
                  if (last_sample) begin
                     sample_index_in = '0;
                     pass_count_in   = pass_next;
                     done_flag_in    = done_next;
                  end else begin
                     sample_index_in = idx_next[IDX_W-1:0];
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         axis_ff         <= 1'b0;
         item_done_ff    <= 1'b0;
         sample_index_ff <= '0;
         pass_count_ff   <= '0;
         done_flag_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         axis_ff         <= axis_in;
         item_done_ff    <= item_done_in;
         sample_index_ff <= sample_index_in;
         pass_count_ff   <= pass_count_in;
         done_flag_ff    <= done_flag_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
      if (req_accept) begin
         desired_h_ff <= req_desired_horizontal;
         desired_v_ff <= req_desired_vertical;
      end
      if (state_ff == ST_DRVSEL) begin
         if (pass_count_ff == '0) begin
            drv_ff <= drv_pass0;
         end else begin
            drv_ff <= axis_ff ? rd_v_ff : rd_h_ff;
         end
      end
      if (state_ff == ST_ANGLE) begin
         angle_ff <= (angle_sum > 13'(ANGLE_MAX)) ? ANGLE_MAX : angle_sum[ANGLE_OUT_W-1:0];
      end
      if (state_ff == ST_GAIN) begin
         err_neg_ff <= err[11];
      end
      if (wr_h) begin
         hold_drv_h_ff   <= drv_ff;
         hold_angle_h_ff <= angle_ff;
      end
   end

   // drive tables, read at the current sample
   always_ff @(posedge clock) begin
      if (wr_h) begin
         table_h_mem[sample_index_ff] <= new_drv;
      end
      if (wr_v) begin
         table_v_mem[sample_index_ff] <= new_drv;
      end
      rd_h_ff <= table_h_mem[sample_index_ff];
      rd_v_ff <= table_v_mem[sample_index_ff];
   end

   // output register
   always_ff @(posedge clock) begin
      if (out_load) begin
         if (item_done_ff) begin
            out_drv_h_ff       <= '0;
            out_drv_v_ff       <= '0;
            out_angle_h_ff     <= '0;
            out_angle_v_ff     <= '0;
            out_pass_end_ff    <= 1'b0;
            out_pass_number_ff <= '0;
            out_finished_ff    <= 1'b1;
         end else begin
            out_drv_h_ff       <= hold_drv_h_ff;
            out_drv_v_ff       <= drv_ff;
            out_angle_h_ff     <= hold_angle_h_ff;
            out_angle_v_ff     <= angle_ff;
            out_pass_end_ff    <= last_sample;
            out_pass_number_ff <= pass_count_ff;
            out_finished_ff    <= done_next;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_drive_horizontal = out_drv_h_ff;
   assign rsp_drive_vertical   = out_drv_v_ff;
   assign rsp_angle_horizontal = out_angle_h_ff;
   assign rsp_angle_vertical   = out_angle_v_ff;
   assign rsp_pass_end         = out_pass_end_ff;
   assign rsp_pass_number      = out_pass_number_ff;
   assign rsp_finished         = out_finished_ff;

endmodule : iterative_learning_servo_control
`default_nettype wire

// ----- hdl/ilsc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ilsc_checker
// Port-level checks of the iterative learning servo control
// ----------------------------------------------------------------------------
module ilsc_checker
   import ilsc_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_stall,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire logic [DRIVE_W-1:0]     rsp_drive_horizontal,
   input wire logic [DRIVE_W-1:0]     rsp_drive_vertical,
   input wire logic [ANGLE_OUT_W-1:0] rsp_angle_horizontal,
   input wire logic [ANGLE_OUT_W-1:0] rsp_angle_vertical,
   input wire logic                   rsp_pass_end
);

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // an accepted item keeps the input side busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken again right after an item");

   // a result that ends no pass after completion carries zero fields
   a_finished_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_drive_horizontal == '0) |->
         (rsp_drive_vertical == '0 && rsp_angle_horizontal == '0 &&
          rsp_angle_vertical == '0 && !rsp_pass_end))
      else $error("finished result carries nonzero fields");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_drive_horizontal) && $stable(rsp_angle_vertical)))
      else $error("stalled result changed");

endmodule : ilsc_checker

bind iterative_learning_servo_control ilsc_checker u_ilsc_checker (.*);
`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-axis iterative learning servo controller.
// Drives trajectory samples through the learning passes and beyond
// completion, predicts every result item from its own model of the tables,
// counters and servo model, and checks each item field by field.
// ----------------------------------------------------------------------------
module tb_top;
   import ilsc_pkg::*;

   localparam int CYCLE_LIMIT    = 300000;
   localparam int SETTLE_CYCLES  = 64;
   localparam int FINISHED_ITEMS = 254;

   typedef struct packed {
      logic [DRIVE_W-1:0]     drive_h;
      logic [DRIVE_W-1:0]     drive_v;
      logic [ANGLE_OUT_W-1:0] angle_h;
      logic [ANGLE_OUT_W-1:0] angle_v;
      logic                   pass_end;
      logic [PASS_W-1:0]      pass_number;
      logic                   finished;
   } servo_sample_type;

   // clock, reset and block ports
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [ANGLE_IN_W-1:0]  req_desired_horizontal = '0;
   logic [ANGLE_IN_W-1:0]  req_desired_vertical = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [DRIVE_W-1:0]     rsp_drive_horizontal;
   logic [DRIVE_W-1:0]     rsp_drive_vertical;
   logic [ANGLE_OUT_W-1:0] rsp_angle_horizontal;
   logic [ANGLE_OUT_W-1:0] rsp_angle_vertical;
   logic                   rsp_pass_end;
   logic [PASS_W-1:0]      rsp_pass_number;
   logic                   rsp_finished;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // predicted register contents
   logic [GAIN_W-1:0]   cfg_learning_gain = RST_LEARNING_GAIN;
   logic [PASS_W-1:0]   cfg_pass_limit    = RST_PASS_LIMIT;
   logic [TRAJ_W-1:0]   cfg_length        = RST_TRAJ_LENGTH;
   logic [MGAIN_W-1:0]  cfg_model_gain    = RST_MODEL_GAIN;
   logic [OFFSET_W-1:0] cfg_model_offset  = RST_MODEL_OFFSET;

   // predicted learning state
   logic [DRIVE_W-1:0]  drive_table_h [MAX_TRAJECTORY];
   logic [DRIVE_W-1:0]  drive_table_v [MAX_TRAJECTORY];
   int                  sample_idx = 0;
   logic [PASS_W-1:0]   pass_cnt = '0;
   logic                learning_done = 1'b0;

   // desired trajectory as sent in pass 0, replayed in later passes
   logic [ANGLE_IN_W-1:0] traj_h [MAX_TRAJECTORY];
   logic [ANGLE_IN_W-1:0] traj_v [MAX_TRAJECTORY];

   servo_sample_type pending_samples [$];
   servo_sample_type oldest_sample;
   int               gap_percent = 0;
   int               stall_percent = 0;
   int               error_count = 0;
   int               cycle_count = 0;

   iterative_learning_servo_control u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_desired_horizontal (req_desired_horizontal),
      .req_desired_vertical   (req_desired_vertical),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_drive_horizontal   (rsp_drive_horizontal),
      .rsp_drive_vertical     (rsp_drive_vertical),
      .rsp_angle_horizontal   (rsp_angle_horizontal),
      .rsp_angle_vertical     (rsp_angle_vertical),
      .rsp_pass_end           (rsp_pass_end),
      .rsp_pass_number        (rsp_pass_number),
      .rsp_finished           (rsp_finished),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_percent);
   end

   // ---------------------------------------------------------------------
   // servo model and learning law
   // ---------------------------------------------------------------------

   // pass-0 drive straight from the desired angle
   function automatic int pwm_from_angle(int desired);
      int d;
      d = (desired > int'(ANGLE_FULL)) ? int'(ANGLE_FULL) : desired;
      return int'(PWM_LOW) + d * (int'(PWM_HIGH) - int'(PWM_LOW)) / int'(ANGLE_FULL);
   endfunction

   function automatic int modelled_angle(int drive);
      int d, ideal, ang;
      d = drive;
      if (d < int'(PWM_LOW)) d = int'(PWM_LOW);
      if (d > int'(PWM_HIGH)) d = int'(PWM_HIGH);
      ideal = (d - int'(PWM_LOW)) * int'(ANGLE_FULL) / (int'(PWM_HIGH) - int'(PWM_LOW));
      ang = ideal * int'(cfg_model_gain) / 100 + int'(cfg_model_offset);
      if (ang > int'(ANGLE_MAX)) ang = int'(ANGLE_MAX);
      return ang;
   endfunction

   // p-type update, division truncates toward zero
   function automatic int learned_drive(int old, int desired, int angle);
      int err, delta, updated;
      err = desired - angle;
      delta = (int'(cfg_learning_gain) * err) / 100;
      updated = old + delta;
      if (updated < int'(PWM_LOW)) updated = int'(PWM_LOW);
      if (updated > int'(PWM_HIGH)) updated = int'(PWM_HIGH);
      return updated;
   endfunction

   function automatic int pass_length();
      int len;
      len = int'(cfg_length);
      if (len == 0) len = 1;
      if (len > MAX_TRAJECTORY) len = MAX_TRAJECTORY;
      return len;
   endfunction

   // expected result of one sample, advancing the learning state
   function automatic servo_sample_type predict_servo_sample(
      logic [ANGLE_IN_W-1:0] des_h,
      logic [ANGLE_IN_W-1:0] des_v
   );
      servo_sample_type s;
      int len, limit, idx, drv_h, drv_v, ang_h, ang_v;
      logic last;
      s = '0;
      // finished: all zero apart from the flag, nothing moves
      if (learning_done) begin
         s.finished = 1'b1;
         return s;
      end
      len = pass_length();
      limit = (cfg_pass_limit == 0) ? 1 : int'(cfg_pass_limit);
      idx = (sample_idx >= MAX_TRAJECTORY) ? MAX_TRAJECTORY - 1 : sample_idx;
      if (pass_cnt == 0) begin
         drv_h = pwm_from_angle(int'(des_h));
         drv_v = pwm_from_angle(int'(des_v));
      end else begin
         drv_h = int'(drive_table_h[idx]);
         drv_v = int'(drive_table_v[idx]);
      end
      ang_h = modelled_angle(drv_h);
      ang_v = modelled_angle(drv_v);
      drive_table_h[idx] = DRIVE_W'(learned_drive(drv_h, int'(des_h), ang_h));
      drive_table_v[idx] = DRIVE_W'(learned_drive(drv_v, int'(des_v), ang_v));
      s.drive_h = DRIVE_W'(drv_h);
      s.drive_v = DRIVE_W'(drv_v);
      s.angle_h = ANGLE_OUT_W'(ang_h);
      s.angle_v = ANGLE_OUT_W'(ang_v);
      s.pass_number = pass_cnt;
      // a shrunk length makes any index at or past its end the last sample
      last = (idx + 1 >= len);
      if (last) begin
         sample_idx = 0;
         pass_cnt = pass_cnt + 1'b1;
         if (int'(pass_cnt) >= limit) learning_done = 1'b1;
      end else begin
         sample_idx = idx + 1;
      end
      s.pass_end = last;
      s.finished = learning_done;
      return s;
   endfunction

   function automatic logic [ANGLE_IN_W-1:0] random_angle();
      if ($urandom_range(9) == 0) return ANGLE_IN_W'($urandom_range(2047, 1801));
      return ANGLE_IN_W'($urandom_range(1800));
   endfunction

   // ---------------------------------------------------------------------
   // result checking
   // ---------------------------------------------------------------------

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_samples.size() == 0) begin
            $display("%0t ns: result item with none expected, expected none actual drive %0d/%0d",
                     $time, rsp_drive_horizontal, rsp_drive_vertical);
            error_count++;
         end else begin
            oldest_sample = pending_samples.pop_front();
            check_field("drive_horizontal", oldest_sample.drive_h, rsp_drive_horizontal);
            check_field("drive_vertical", oldest_sample.drive_v, rsp_drive_vertical);
            check_field("angle_horizontal", oldest_sample.angle_h, rsp_angle_horizontal);
            check_field("angle_vertical", oldest_sample.angle_v, rsp_angle_vertical);
            check_field("pass_end", oldest_sample.pass_end, rsp_pass_end);
            check_field("pass_number", oldest_sample.pass_number, rsp_pass_number);
            check_field("finished", oldest_sample.finished, rsp_finished);
         end
      end
   end

   // ---------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------

   task automatic set_idling(int gap, int stall);
      gap_percent = gap;
      stall_percent = stall;
   endtask

   // register write, to be made only while the block is idle; the task does not enforce it
   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_LEARNING_GAIN:      cfg_learning_gain = data[GAIN_W-1:0];
         CSR_PASS_LIMIT:         cfg_pass_limit = data[PASS_W-1:0];
         CSR_TRAJECTORY_LENGTH:  cfg_length = data[TRAJ_W-1:0];
         CSR_MODEL_GAIN_PERCENT: cfg_model_gain = data[MGAIN_W-1:0];
         CSR_MODEL_OFFSET:       cfg_model_offset = data[OFFSET_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // one sample item; valid stays high if the next call follows at once
   task automatic send_desired(logic [ANGLE_IN_W-1:0] des_h, logic [ANGLE_IN_W-1:0] des_v);
      @(negedge clock);
      while ($urandom_range(99) < gap_percent) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_desired_horizontal <= des_h;
      req_desired_vertical <= des_v;
      do @(posedge clock); while (req_stall);
      if (!learning_done && pass_cnt == 0) begin
         traj_h[sample_idx] = des_h;
         traj_v[sample_idx] = des_v;
      end
      pending_samples.push_back(predict_servo_sample(des_h, des_v));
   endtask

   // mostly the repeated trajectory, sometimes a stray sample
   task automatic send_trajectory_sample();
      if ($urandom_range(99) < 85)
         send_desired(traj_h[sample_idx], traj_v[sample_idx]);
      else
         send_desired(random_angle(), random_angle());
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
   endtask

   task automatic write_random_model();
      write_csr(CSR_LEARNING_GAIN, CSR_DATA_W'($urandom_range(255)));
      write_csr(CSR_MODEL_GAIN_PERCENT, CSR_DATA_W'($urandom_range(127)));
      write_csr(CSR_MODEL_OFFSET, CSR_DATA_W'($urandom_range(255)));
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // pass 0 under the reset register values
   task automatic test_reset_defaults();
      set_idling(0, 0);
      send_desired(11'd0, 11'd0);
      send_desired(11'd1800, 11'd1800);
      send_desired(11'd2047, 11'd0);
      send_desired(11'd900, 11'd1799);
      drain_results();
   endtask

   // drive conversion at the field extremes, modelled angle saturating
   task automatic test_conversion_extremes();
      write_csr(CSR_LEARNING_GAIN, 8'hFF);
      write_csr(CSR_PASS_LIMIT, 8'hFF);
      // 63 is past the store depth and acts as a full-length trajectory
      write_csr(CSR_TRAJECTORY_LENGTH, 8'hFF);
      write_csr(CSR_MODEL_GAIN_PERCENT, 8'd127);
      write_csr(CSR_MODEL_OFFSET, 8'd255);
      send_desired(11'd0, 11'd2047);
      send_desired(11'd2047, 11'd0);
      send_desired(11'd1800, 11'd1799);
      send_desired(11'd1801, 11'd1);
      send_desired(11'd1024, 11'd1023);
      send_desired(11'd0, 11'd0);
      send_desired(11'd2047, 11'd2047);
      send_desired(11'd900, 11'd450);
      drain_results();
   endtask

   // servo model at zero and full gain, and writes to unused indexes
   task automatic test_model_extremes();
      int i;
      write_csr(CSR_LEARNING_GAIN, 8'd0);
      write_csr(CSR_MODEL_GAIN_PERCENT, 8'd0);
      write_csr(CSR_MODEL_OFFSET, 8'd0);
      send_desired(11'd1800, 11'd0);
      send_desired(11'd0, 11'd1800);
      send_desired(11'd1234, 11'd567);
      send_desired(11'd2047, 11'd2047);
      drain_results();
      write_csr(CSR_LEARNING_GAIN, 8'd1);
      write_csr(CSR_MODEL_GAIN_PERCENT, 8'd100);
      write_csr(CSR_MODEL_OFFSET, 8'd128);
      for (i = int'(CSR_MODEL_OFFSET) + 1; i < (1 << CSR_INDEX_W); i++)
         write_csr(CSR_INDEX_W'(i), CSR_DATA_W'($urandom_range(255)));
      send_desired(11'd1799, 11'd1);
      send_desired(11'd1, 11'd1799);
      send_desired(11'd1365, 11'd682);
      send_desired(11'd2046, 11'd1025);
      drain_results();
   endtask

   // finish pass 0 so every table entry holds a learned drive
   task automatic test_pass_zero_fill();
      write_csr(CSR_LEARNING_GAIN, 8'd47);
      write_csr(CSR_MODEL_GAIN_PERCENT, 8'd60);
      write_csr(CSR_MODEL_OFFSET, 8'd20);
      while (pass_cnt == 0) send_desired(random_angle(), random_angle());
      drain_results();
   endtask

   // length cut below the current index, then length zero
   task automatic test_length_shrink();
      set_idling(47, 0);
      write_csr(CSR_TRAJECTORY_LENGTH, 8'd32);
      repeat (5) send_trajectory_sample();
      drain_results();
      write_csr(CSR_TRAJECTORY_LENGTH, 8'd3);
      send_trajectory_sample();
      drain_results();
      write_csr(CSR_TRAJECTORY_LENGTH, 8'd0);
      send_trajectory_sample();
      drain_results();
   endtask

   // full learning passes with random gains; the last one completes the run
   task automatic test_learning_passes();
      int first_gap [3]    = '{0, 0, 38};
      int first_stall [3]  = '{0, 47, 38};
      int second_gap [3]   = '{47, 38, 0};
      int second_stall [3] = '{0, 38, 0};
      int p, k, n;
      write_csr(CSR_PASS_LIMIT, 8'd6);
      for (p = 0; p < 3; p++) begin
         // zero acts as one, so the pass under way becomes the final one
         if (p == 2) write_csr(CSR_PASS_LIMIT, 8'd0);
         write_random_model();
         write_csr(CSR_TRAJECTORY_LENGTH, {2'($urandom_range(3)), 6'($urandom_range(63, 8))});
         n = pass_length();
         set_idling(first_gap[p], first_stall[p]);
         for (k = 0; k < n; k++) begin
            if (k == n / 2) set_idling(second_gap[p], second_stall[p]);
            send_trajectory_sample();
         end
         drain_results();
      end
   endtask

   // after completion nothing, not even a register write, restarts learning
   task automatic test_finished_hold();
      int gaps [4]   = '{0, 47, 0, 38};
      int stalls [4] = '{0, 0, 47, 38};
      int ph;
      for (ph = 0; ph < 4; ph++) begin
         write_random_model();
         write_csr(CSR_PASS_LIMIT, CSR_DATA_W'($urandom_range(255)));
         write_csr(CSR_TRAJECTORY_LENGTH, CSR_DATA_W'($urandom_range(255)));
         set_idling(gaps[ph], stalls[ph]);
         repeat (FINISHED_ITEMS)
            send_desired(ANGLE_IN_W'($urandom_range(2047)), ANGLE_IN_W'($urandom_range(2047)));
         drain_results();
      end
   endtask

   // ---------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_conversion_extremes();
      test_model_extremes();
      test_pass_zero_fill();
      test_length_shrink();
      test_learning_passes();
      test_finished_hold();
      set_idling(0, 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_samples.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
